// ===== hw/rtl/hsv_to_rgb_converter_macros.svh =====
// ---------------------------------------------------------------------------
// hsv_to_rgb_converter assertion macros
// concurrent checks shared by the colour converter, clocked on clk
// ---------------------------------------------------------------------------
`ifndef HSV_TO_RGB_CONVERTER_MACROS_SVH
`define HSV_TO_RGB_CONVERTER_MACROS_SVH

// same-cycle implication, held off while in reset
`define HSVRGB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hsv_to_rgb_converter: check failed");

// next-cycle implication, held off while in reset
`define HSVRGB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hsv_to_rgb_converter: check failed");

`endif

// ===== hw/rtl/hsvrgb_pkg.sv =====
// ---------------------------------------------------------------------------
// hsvrgb_pkg
// types and fixed constants of the hsv to rgb colour converter
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hsvrgb_pkg;

  // field widths
  localparam int unsigned HUE_W  = 15;
  localparam int unsigned CH_W   = 8;
  localparam int unsigned FRAC_W = 12;
  localparam int unsigned CLS_W  = 3;
  localparam int unsigned RAW_W  = 4;

  // scaling constants
  localparam int unsigned SECTOR_SPAN = 3840;
  localparam int unsigned NUM_BOUNDS  = 8;
  localparam int unsigned FULL_SCALE  = 255;
  localparam int unsigned QT_DEN      = FULL_SCALE * SECTOR_SPAN;
  localparam int unsigned QT_HALF     = QT_DEN / 2;
  localparam int unsigned P_HALF      = FULL_SCALE / 2;

  // q/t path widths
  localparam int unsigned QT_DEN_W = 20;
  localparam int unsigned QT_NUM_W = 28;
  localparam int unsigned P_NUM_W  = 16;
  localparam int unsigned EST_W    = 9;

  // reciprocals for division by constant, each followed by one correction
  localparam int unsigned QT_RECIP_SHIFT = 40;
  localparam int unsigned QT_RECIP_W     = 21;
  localparam logic [QT_RECIP_W-1:0] QT_RECIP =
    QT_RECIP_W'((64'd1 << QT_RECIP_SHIFT) / QT_DEN);
  localparam int unsigned P_RECIP_SHIFT = 24;
  localparam int unsigned P_RECIP_W     = 17;
  localparam logic [P_RECIP_W-1:0] P_RECIP =
    P_RECIP_W'((64'd1 << P_RECIP_SHIFT) / FULL_SCALE);

  // sector classes, anything past magenta-to-red falls into the last one
  localparam logic [CLS_W-1:0] SECT_R_TO_Y = 3'd0;
  localparam logic [CLS_W-1:0] SECT_Y_TO_G = 3'd1;
  localparam logic [CLS_W-1:0] SECT_G_TO_C = 3'd2;
  localparam logic [CLS_W-1:0] SECT_C_TO_B = 3'd3;
  localparam logic [CLS_W-1:0] SECT_B_TO_M = 3'd4;
  localparam logic [CLS_W-1:0] SECT_M_TO_R = 3'd5;

  // queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // classified pixel handed from front to back
  typedef struct packed {
    logic [CLS_W-1:0]  sector;
    logic [FRAC_W-1:0] frac;
    logic [CH_W-1:0]   sat;
    logic [CH_W-1:0]   val;
  } hsvrgb_item_t;

endpackage

`default_nettype wire

// ===== hw/rtl/hsvrgb_front.sv =====
// ---------------------------------------------------------------------------
// hsvrgb_front
// takes requests, splits hue into sector class and fraction, holds one item
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hsvrgb_front
  import hsvrgb_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [HUE_W-1:0]    in_hue,
  input  wire logic [CH_W-1:0]     in_saturation,
  input  wire logic [CH_W-1:0]     in_value,
  input  wire logic                queue_full,
  output logic                     busy,
  output logic                     item_valid,
  output hsvrgb_item_t             item
);

  logic                valid_r;
  logic                valid_nxt;
  hsvrgb_item_t        item_r;
  logic [RAW_W-1:0]    raw_sector;
  logic [HUE_W-1:0]    sector_base;
  hsvrgb_item_t        item_nxt;
  logic                take;

  // raw sector by counting the 60 degree boundaries passed
  always_comb begin
    raw_sector = '0;
    for (int k = 1; k <= NUM_BOUNDS; k++) begin
      raw_sector = raw_sector + RAW_W'(in_hue >= HUE_W'(k * SECTOR_SPAN));
    end
  end

  // fraction is what is left above the sector start
  assign sector_base = HUE_W'(raw_sector * HUE_W'(SECTOR_SPAN));

  always_comb begin
    item_nxt.frac = FRAC_W'(in_hue - sector_base);
    item_nxt.sat  = in_saturation;
    item_nxt.val  = in_value;
    if (raw_sector >= RAW_W'(SECT_M_TO_R)) begin
      item_nxt.sector = SECT_M_TO_R;
    end else begin
      item_nxt.sector = CLS_W'(raw_sector);
    end
  end

  // hold-off only while the held item cannot enter the queue
  assign busy = valid_r && queue_full;
  assign take = start && !busy;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (!queue_full) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload register
  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= item_nxt;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

`default_nettype wire

// ===== hw/rtl/hsvrgb_queue.sv =====
// ---------------------------------------------------------------------------
// hsvrgb_queue
// short first-in first-out queue between front and back
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hsvrgb_queue
  import hsvrgb_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire hsvrgb_item_t  push_item,
  input  wire logic          pop,
  output logic               full,
  output logic               empty,
  output hsvrgb_item_t       pop_item
);

  hsvrgb_item_t          entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr_r;
  logic [QUEUE_AW-1:0]   rd_ptr_r;
  logic [QUEUE_AW:0]     count_r;
  logic [QUEUE_AW:0]     count_nxt;
  logic                  do_push;
  logic                  do_pop;

  assign full     = count_r == (QUEUE_AW + 1)'(QUEUE_DEPTH);
  assign empty    = count_r == '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_item = entries[rd_ptr_r];

  // occupancy
  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/hsvrgb_back.sv =====
// ---------------------------------------------------------------------------
// hsvrgb_back
// four-stage pipeline forming p, q and t and routing them by sector
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hsvrgb_back
  import hsvrgb_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             item_valid,
  input  wire hsvrgb_item_t     item,
  output logic                  out_valid,
  output logic [CH_W-1:0]       out_red,
  output logic [CH_W-1:0]       out_green,
  output logic [CH_W-1:0]       out_blue
);

  // stage valids
  logic                    s1_valid_r, s2_valid_r, s3_valid_r, s4_valid_r;

  // stage 1: products with saturation
  logic [CLS_W-1:0]        s1_cls_r;
  logic [CH_W-1:0]         s1_val_r;
  logic [QT_DEN_W-1:0]     s1_sq_r;
  logic [QT_DEN_W-1:0]     s1_st_r;
  logic [P_NUM_W-1:0]      s1_pn_r;

  // stage 2: rounded numerators, p estimate
  logic [CLS_W-1:0]        s2_cls_r;
  logic [CH_W-1:0]         s2_val_r;
  logic [QT_NUM_W-1:0]     s2_qn_r;
  logic [QT_NUM_W-1:0]     s2_tn_r;
  logic [P_NUM_W-1:0]      s2_pn_r;
  logic [EST_W-1:0]        s2_pe_r;

  // stage 3: q and t estimates, p finished
  logic [CLS_W-1:0]        s3_cls_r;
  logic [CH_W-1:0]         s3_val_r;
  logic [QT_NUM_W-1:0]     s3_qn_r;
  logic [QT_NUM_W-1:0]     s3_tn_r;
  logic [EST_W-1:0]        s3_qe_r;
  logic [EST_W-1:0]        s3_te_r;
  logic [CH_W-1:0]         s3_p_r;

  // stage 4: output registers
  logic [CH_W-1:0]         red_r, green_r, blue_r;

  logic [QT_DEN_W-1:0]     s1_sq_nxt, s1_st_nxt;
  logic [P_NUM_W-1:0]      s1_pn_nxt;
  logic [QT_NUM_W-1:0]     s2_qn_nxt, s2_tn_nxt;
  logic [EST_W-1:0]        s2_pe_nxt;
  logic [P_NUM_W+P_RECIP_W-1:0]     p_prod;
  logic [QT_NUM_W+QT_RECIP_W-1:0]   q_prod, t_prod;
  logic [P_NUM_W-1:0]      p_rem;
  logic [CH_W-1:0]         s3_p_nxt;
  logic [QT_NUM_W-1:0]     q_rem, t_rem;
  logic [CH_W-1:0]         q_val, t_val;
  logic [CH_W-1:0]         red_nxt, green_nxt, blue_nxt;

  // saturation times fraction for q and t, value times (1 - s) for p
  assign s1_sq_nxt = QT_DEN_W'(item.sat) * QT_DEN_W'(item.frac);
  assign s1_st_nxt = QT_DEN_W'(item.sat) * QT_DEN_W'(FRAC_W'(SECTOR_SPAN) - item.frac);
  assign s1_pn_nxt = P_NUM_W'(item.val) * P_NUM_W'(CH_W'(FULL_SCALE) - item.sat)
                     + P_NUM_W'(P_HALF);

  // numerators with half the divisor added for rounding
  assign s2_qn_nxt = QT_NUM_W'(s1_val_r) * QT_NUM_W'(QT_DEN_W'(QT_DEN) - s1_sq_r)
                     + QT_NUM_W'(QT_HALF);
  assign s2_tn_nxt = QT_NUM_W'(s1_val_r) * QT_NUM_W'(QT_DEN_W'(QT_DEN) - s1_st_r)
                     + QT_NUM_W'(QT_HALF);
  assign p_prod    = (P_NUM_W + P_RECIP_W)'(s1_pn_r) * (P_NUM_W + P_RECIP_W)'(P_RECIP);
  assign s2_pe_nxt = p_prod[P_RECIP_SHIFT +: EST_W];

  // reciprocal estimates for q and t, one-step correction for p
  assign q_prod = (QT_NUM_W + QT_RECIP_W)'(s2_qn_r) * (QT_NUM_W + QT_RECIP_W)'(QT_RECIP);
  assign t_prod = (QT_NUM_W + QT_RECIP_W)'(s2_tn_r) * (QT_NUM_W + QT_RECIP_W)'(QT_RECIP);
  assign p_rem  = s2_pn_r - P_NUM_W'(s2_pe_r) * P_NUM_W'(FULL_SCALE);
  assign s3_p_nxt = (p_rem >= P_NUM_W'(FULL_SCALE)) ? CH_W'(s2_pe_r + 1'b1)
                                                   : CH_W'(s2_pe_r);

  // correction for q and t
  assign q_rem = s3_qn_r - QT_NUM_W'(s3_qe_r) * QT_NUM_W'(QT_DEN);
  assign t_rem = s3_tn_r - QT_NUM_W'(s3_te_r) * QT_NUM_W'(QT_DEN);
  assign q_val = (q_rem >= QT_NUM_W'(QT_DEN)) ? CH_W'(s3_qe_r + 1'b1) : CH_W'(s3_qe_r);
  assign t_val = (t_rem >= QT_NUM_W'(QT_DEN)) ? CH_W'(s3_te_r + 1'b1) : CH_W'(s3_te_r);

  // channel routing by sector
  always_comb begin
    case (s3_cls_r)
      SECT_R_TO_Y: begin
        red_nxt = s3_val_r; green_nxt = t_val;    blue_nxt = s3_p_r;
      end
      SECT_Y_TO_G: begin
        red_nxt = q_val;    green_nxt = s3_val_r; blue_nxt = s3_p_r;
      end
      SECT_G_TO_C: begin
        red_nxt = s3_p_r;   green_nxt = s3_val_r; blue_nxt = t_val;
      end
      SECT_C_TO_B: begin
        red_nxt = s3_p_r;   green_nxt = q_val;    blue_nxt = s3_val_r;
      end
      SECT_B_TO_M: begin
        red_nxt = t_val;    green_nxt = s3_p_r;   blue_nxt = s3_val_r;
      end
      default: begin
        red_nxt = s3_val_r; green_nxt = s3_p_r;   blue_nxt = q_val;
      end
    endcase
  end

  // valid pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= item_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
      s4_valid_r <= s3_valid_r;
    end
  end

  // payload pipeline
  always_ff @(posedge clk) begin
    s1_cls_r <= item.sector;
    s1_val_r <= item.val;
    s1_sq_r  <= s1_sq_nxt;
    s1_st_r  <= s1_st_nxt;
    s1_pn_r  <= s1_pn_nxt;

    s2_cls_r <= s1_cls_r;
    s2_val_r <= s1_val_r;
    s2_qn_r  <= s2_qn_nxt;
    s2_tn_r  <= s2_tn_nxt;
    s2_pn_r  <= s1_pn_r;
    s2_pe_r  <= s2_pe_nxt;

    s3_cls_r <= s2_cls_r;
    s3_val_r <= s2_val_r;
    s3_qn_r  <= s2_qn_r;
    s3_tn_r  <= s2_tn_r;
    s3_qe_r  <= q_prod[QT_RECIP_SHIFT +: EST_W];
    s3_te_r  <= t_prod[QT_RECIP_SHIFT +: EST_W];
    s3_p_r   <= s3_p_nxt;

    red_r    <= red_nxt;
    green_r  <= green_nxt;
    blue_r   <= blue_nxt;
  end

  assign out_valid = s4_valid_r;
  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;

endmodule

`default_nettype wire

// ===== hw/rtl/hsv_to_rgb_converter.sv =====
// ---------------------------------------------------------------------------
// hsv_to_rgb_converter
// hsv pixel to 8-bit rgb: front classifier, two-entry queue, four-stage back
// ---------------------------------------------------------------------------
// path: a taken request reaches out_valid through the front register, the queue and the four back stages
// throughput: one pixel per clock, set by the fully pipelined back end
// busy stays low in operation, since the back end never stalls
// reset: synchronous, active low, clears front, queue and pipeline valids
`timescale 1ns / 1ps
`default_nettype none

`include "hsv_to_rgb_converter_macros.svh"

module hsv_to_rgb_converter
  import hsvrgb_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [HUE_W-1:0]   in_hue,
  input  wire logic [CH_W-1:0]    in_saturation,
  input  wire logic [CH_W-1:0]    in_value,
  output logic                    out_valid,
  output logic [CH_W-1:0]         out_red,
  output logic [CH_W-1:0]         out_green,
  output logic [CH_W-1:0]         out_blue
);

  logic          f_valid;
  hsvrgb_item_t  f_item;
  logic          q_full;
  logic          q_empty;
  hsvrgb_item_t  q_item;

  // front: request capture and hue classification
  hsvrgb_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .in_hue        (in_hue),
    .in_saturation (in_saturation),
    .in_value      (in_value),
    .queue_full    (q_full),
    .busy          (busy),
    .item_valid    (f_valid),
    .item          (f_item)
  );

  // queue between the two halves
  hsvrgb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_valid),
    .push_item (f_item),
    .pop       (!q_empty),
    .full      (q_full),
    .empty     (q_empty),
    .pop_item  (q_item)
  );

  // back: arithmetic and channel routing
  hsvrgb_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (!q_empty),
    .item       (q_item),
    .out_valid  (out_valid),
    .out_red    (out_red),
    .out_green  (out_green),
    .out_blue   (out_blue)
  );

  // checks
  `HSVRGB_ASSERT_IMP(a_never_busy, 1'b1, !busy)
  `HSVRGB_ASSERT_NXT(a_request_held, start && !busy, f_valid)
  `HSVRGB_ASSERT_IMP(a_result_follows, start && !busy, ##6 out_valid)
  `HSVRGB_ASSERT_IMP(a_queue_shallow, 1'b1, !q_full)

endmodule

`default_nettype wire
